[sv/ssnl_pkg.sv]
// Shared constants and types for the shift-subtract natural log pipeline.
package ssnl_pkg;

	localparam int LOG_STAGES      = 15;
	localparam int SHIFT_STAGES    = 4;
	localparam int STEPS_PER_STAGE = 3;
	localparam int PIPE_STAGES     = LOG_STAGES / STEPS_PER_STAGE;
	localparam int ACC_WIDTH       = 15;
	localparam int ONE_FIXED       = 512;

	typedef logic [ACC_WIDTH-1:0] acc_t;
	typedef logic [3:0]           shamt_t;

	localparam acc_t STAGE_ADD [LOG_STAGES] = '{
		15'd11357, 15'd5678, 15'd2839, 15'd1420, 15'd830, 15'd457, 15'd241, 15'd124,
		15'd63, 15'd32, 15'd16, 15'd8, 15'd4, 15'd2, 15'd1
	};

	localparam shamt_t STAGE_SHIFT [LOG_STAGES] = '{
		4'd8, 4'd4, 4'd2, 4'd1, 4'd1, 4'd2, 4'd3, 4'd4,
		4'd5, 4'd6, 4'd7, 4'd8, 4'd9, 4'd10, 4'd11
	};

endpackage

[sv/ssnl_stage.sv]
// One registered pipeline stage applying three consecutive log steps.
module ssnl_stage #(
	parameter int W     = 24,
	parameter int FIRST = 0
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [W-1:0]        w_in,
	input  ssnl_pkg::acc_t      acc_in,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [W-1:0]        w_out,
	output ssnl_pkg::acc_t      acc_out
);
	import ssnl_pkg::*;

	logic [W-1:0] w_c;
	acc_t         acc_c;
	logic [W-1:0] cand;
	logic         valid_s1;
	logic [W-1:0] w_s1;
	acc_t         acc_s1;

	always_comb begin
		w_c   = w_in;
		acc_c = acc_in;
		cand  = '0;
		for (int i = 0; i < STEPS_PER_STAGE; i++) begin
			if (FIRST + i < SHIFT_STAGES) begin
				cand = w_c >> STAGE_SHIFT[FIRST + i];
			end else begin
				cand = w_c - (w_c >> STAGE_SHIFT[FIRST + i]);
			end
			if (cand >= W'(ONE_FIXED)) begin
				w_c   = cand;
				acc_c = acc_c + STAGE_ADD[FIRST + i];
			end
		end
	end

	assign in_ready = !valid_s1 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	// hold payload unless a new item moves in
	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			w_s1   <= w_c;
			acc_s1 <= acc_c;
		end
	end

	assign out_valid = valid_s1;
	assign w_out     = w_s1;
	assign acc_out   = acc_s1;

endmodule

[sv/shift_subtract_natural_log_unit.sv]
// Top level of the pipelined shift-subtract natural log unit.
//
//  channel  | handshake                   | payload
//  ---------+-----------------------------+------------------------------
//  input    | in_valid  / in_stall (out)  | x_in    [INPUT_WIDTH-1:0]
//  output   | out_valid / out_stall (in)  | log_out [14:0]
//
// Five register stages of three log steps each: one item per cycle while
// out_stall is low. Reset clears only the stage valid bits.
// A stage takes a new item when it is empty or its successor takes its own,
// so bubbles are squeezed out while out_stall is high; in_stall rises only
// when every stage holds an item and the output is stalled.
module shift_subtract_natural_log_unit #(
	parameter int INPUT_WIDTH = 24
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic [INPUT_WIDTH-1:0] x_in,
	output logic                   out_valid,
	input  logic                   out_stall,
	output logic [14:0]            log_out
);
	import ssnl_pkg::*;

	logic                   valid_c [PIPE_STAGES+1];
	logic                   ready_c [PIPE_STAGES+1];
	logic [INPUT_WIDTH-1:0] w_c     [PIPE_STAGES+1];
	acc_t                   acc_c   [PIPE_STAGES+1];

	assign valid_c[0] = in_valid;
	assign w_c[0]     = x_in;
	assign acc_c[0]   = '0;
	assign in_stall   = !ready_c[0];

	for (genvar g = 0; g < PIPE_STAGES; g++) begin : g_stage
		ssnl_stage #(
			.W     (INPUT_WIDTH),
			.FIRST (g * STEPS_PER_STAGE)
		) u_stage (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (valid_c[g]),
			.in_ready  (ready_c[g]),
			.w_in      (w_c[g]),
			.acc_in    (acc_c[g]),
			.out_valid (valid_c[g+1]),
			.out_ready (ready_c[g+1]),
			.w_out     (w_c[g+1]),
			.acc_out   (acc_c[g+1])
		);
	end

	assign ready_c[PIPE_STAGES] = !out_stall;
	assign out_valid            = valid_c[PIPE_STAGES];
	assign log_out              = acc_c[PIPE_STAGES];

endmodule

[test/tb_shift_subtract_natural_log_unit.sv]
// Testbench for the shift-subtract natural log unit: random and corner operands.
`timescale 1ns / 1ps

module tb_shift_subtract_natural_log_unit;

	import ssnl_pkg::acc_t;

	localparam int XW      = 24;
	localparam int N_STEPS = 15;
	localparam int N_SHIFT = 4;
	localparam int UNITY   = 512;
	localparam int N_RAND  = 1100;

	localparam int unsigned LN_ADD [N_STEPS] = '{
		11357, 5678, 2839, 1420, 830, 457, 241, 124, 63, 32, 16, 8, 4, 2, 1
	};
	localparam int unsigned LN_SHIFT [N_STEPS] = '{
		8, 4, 2, 1, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10, 11
	};

	typedef struct {
		logic [XW-1:0] operand;
		acc_t          log_val;
	} pending_t;

	class ln_scoreboard;
		pending_t pending_log[$];
		bit       bad;

		function acc_t natural_log_of(logic [XW-1:0] x);
			logic [XW-1:0] w;
			logic [XW-1:0] cand;
			logic [31:0]   sum;
			w   = x;
			sum = 0;
			for (int s = 0; s < N_STEPS; s++) begin
				if (s < N_SHIFT)
					cand = w >> LN_SHIFT[s];
				else
					cand = w - (w >> LN_SHIFT[s]);
				if (cand >= UNITY) begin
					w   = cand;
					sum = sum + LN_ADD[s];
				end
			end
			return sum[14:0];
		endfunction

		function void note_operand(logic [XW-1:0] x);
			pending_t p;
			p.operand = x;
			p.log_val = natural_log_of(x);
			pending_log.push_back(p);
		endfunction

		function void check_log(acc_t got);
			pending_t p;
			if (pending_log.size() == 0) begin
				$display("%0t: log_out %0d with no item outstanding", $time, got);
				bad = 1'b1;
				return;
			end
			p = pending_log.pop_front();
			if (got !== p.log_val) begin
				$display("%0t: x_in %0d log_out expected %0d, actual %0d",
					$time, p.operand, p.log_val, got);
				bad = 1'b1;
			end
		endfunction

		function int outstanding();
			return pending_log.size();
		endfunction
	endclass

	logic          clk;
	logic          arst_n;
	logic          in_valid;
	logic          in_stall;
	logic [XW-1:0] x_in;
	logic          out_valid;
	logic          out_stall;
	logic [14:0]   log_out;
	bit            calm;

	ln_scoreboard sb = new();

	shift_subtract_natural_log_unit #(
		.INPUT_WIDTH(XW)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.x_in     (x_in),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.log_out  (log_out)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#1000000;
		$display("shift_subtract_natural_log_unit: mismatch");
		$finish;
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic logic [XW-1:0] pick_operand();
		int            r;
		int            len;
		logic [XW-1:0] v;
		r = $urandom_range(0, 99);
		if (r < 35)
			return XW'($urandom());
		if (r < 75) begin
			len = $urandom_range(1, XW);
			v   = XW'($urandom() & ((32'd1 << len) - 1));
			v[len-1] = 1'b1;
			return v;
		end
		if (r < 90)
			return XW'($urandom_range(470, 620));
		return XW'($urandom_range(0, UNITY - 1));
	endfunction

	// record accepted operands before checking results of the same edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall)
				sb.note_operand(x_in);
			if (out_valid && !out_stall)
				sb.check_log(log_out);
		end
	end

	initial begin
		int hold;
		int run;
		out_stall = 1'b0;
		@(posedge arst_n);
		@(posedge clk);
		forever begin
			hold = calm ? 0 : pick_gap();
			run  = pick_gap();
			if (hold > 0) begin
				out_stall <= 1'b1;
				repeat (hold) @(posedge clk);
			end
			out_stall <= 1'b0;
			repeat (run + 1) @(posedge clk);
		end
	end

	task automatic drive_item(input logic [XW-1:0] v);
		in_valid <= 1'b1;
		x_in     <= v;
		do
			@(posedge clk);
		while (in_stall);
	endtask

	task automatic idle_gap(input int n);
		if (n > 0) begin
			in_valid <= 1'b0;
			x_in     <= XW'($urandom());
			repeat (n) @(posedge clk);
		end
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.outstanding() != 0)
			@(posedge clk);
	endtask

	initial begin
		logic [XW-1:0] corner[$];
		in_valid = 1'b0;
		x_in     = '0;
		calm     = 1'b0;
		arst_n   = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		corner = '{24'd0, 24'd1, 24'd511, 24'd512, 24'd513, 24'd1023, 24'd1024,
			24'd1392, 24'd1536, 24'd2047, 24'd131071, 24'd131072, 24'd262144,
			24'hFFFFFF, 24'h800000, 24'h7FFFFF, 24'hAAAAAA, 24'h555555,
			24'h000200, 24'h0001FF, 24'h400000, 24'h010000, 24'hFFFE00};
		foreach (corner[i]) begin
			drive_item(corner[i]);
			idle_gap(i % 3);
		end

		// hold the sender until the pipeline is empty
		drain();

		for (int i = 0; i < N_RAND; i++) begin
			calm = (i >= 500 && i < 650);
			drive_item(pick_operand());
			if (i == 300)
				drain();
			else if (!calm)
				idle_gap(pick_gap());
		end
		calm = 1'b1;
		drain();
		in_valid <= 1'b0;
		repeat (20) @(posedge clk);

		if (!sb.bad && sb.outstanding() == 0)
			$display("shift_subtract_natural_log_unit: match");
		else
			$display("shift_subtract_natural_log_unit: mismatch");
		$finish;
	end

endmodule
